FILE: rtl/core/ssbs_pkg.sv
// Package for the sorted store with binary search.
// Holds the controller state codes, datapath operation codes and the
// command and status structs shared by the controller and the datapath.
package ssbs_pkg;

   // Controller states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH_J,
      ST_COMPARE,
      ST_WRITE_I,
      ST_PROBE,
      ST_DECIDE,
      ST_RD_LOW,
      ST_RD_HIGH,
      ST_REPLY
   } state_type;

   // Datapath operations, one per cycle
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_LOAD,
      OP_START,
      OP_FETCH_J,
      OP_COMPARE,
      OP_WRITE_I,
      OP_PROBE,
      OP_DECIDE,
      OP_FETCH_LOW,
      OP_FETCH_HIGH
   } op_type;

   typedef struct packed {
      op_type op;
      logic   rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic single;
      logic j_last;
      logic i_last;
      logic range_empty;
      logic hit;
      logic rsp_full;
   } status_type;

   // Function codes of an input word
   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   // Register map: paddr[2] selects the register on a write; a read decodes the whole paddr
   localparam logic REG_ELEMENT_COUNT = 1'b0;

   localparam int         COUNT_W     = 7;
   localparam logic [6:0] COUNT_RESET = 7'd3;
   localparam int         VALUE_W     = 32;
   localparam int         POS_W       = 6;
   localparam int         CSR_DW      = 32;
   localparam int         CSR_AW      = 3;

endpackage

FILE: rtl/core/ssbs_dp.sv
// Datapath of the sorted store: the store memory, sort and search index
// registers, comparators and the result register.
// Depends on ssbs_pkg for the command and status structs.
module ssbs_dp #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ssbs_pkg::cmd_type                cmd,
   output ssbs_pkg::status_type             status,
   input  logic signed [ssbs_pkg::VALUE_W-1:0] req_value,
   input  logic [ssbs_pkg::COUNT_W-1:0]     count,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic                             rsp_found,
   output logic [ssbs_pkg::POS_W-1:0]       rsp_position,
   output logic signed [ssbs_pkg::VALUE_W-1:0] rsp_lowest,
   output logic signed [ssbs_pkg::VALUE_W-1:0] rsp_highest
);

   localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int LW  = CW + 1;
   localparam int XW  = CW + ssbs_pkg::COUNT_W;
   localparam int PSW = ssbs_pkg::POS_W;
   localparam int VW  = ssbs_pkg::VALUE_W;

   // Sign-extend or truncate a stored entry to a result word
   function automatic logic signed [VW-1:0] to_word(input logic signed [WIDTH-1:0] w);
      logic signed [63:0] ext;
      ext = 64'(w);
      return ext[VW-1:0];
   endfunction

   logic signed [WIDTH-1:0] mem [DEPTH];
   logic signed [WIDTH-1:0] rd_data_ff;

   logic [PW-1:0]           clr_ff, clr_in;
   logic [PW-1:0]           wp_ff, wp_in;
   logic [PW-1:0]           i_ff, i_in;
   logic [PW-1:0]           j_ff, j_in;
   logic signed [WIDTH-1:0] key_ff, key_in;
   logic signed [WIDTH-1:0] cur_ff, cur_in;
   logic signed [LW-1:0]    low_ff, low_in;
   logic signed [LW-1:0]    high_ff, high_in;
   logic                    found_ff, found_in;
   logic [PW-1:0]           hit_ff, hit_in;
   logic signed [WIDTH-1:0] lowest_ff, lowest_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff;
   logic [PSW-1:0]          rsp_position_ff;
   logic signed [VW-1:0]    rsp_lowest_ff, rsp_highest_ff;

   logic [XW-1:0]           cnt_x;
   logic [CW-1:0]           n_w;
   logic [PW-1:0]           last_idx;
   logic signed [WIDTH-1:0] key_w;
   logic [PW-1:0]           wp_eff;
   logic [CW-1:0]           wp_inc;
   logic signed [LW:0]      mid_sum;
   logic signed [LW-1:0]    mid_s;
   logic [PW-1:0]           mid;
   logic                    swap;
   logic                    key_eq, key_lt;

   logic                    wr_en, rd_en;
   logic [PW-1:0]           wr_addr, rd_addr;
   logic signed [WIDTH-1:0] wr_data;

   // Clamp the entry count to 1..DEPTH
   always_comb begin
      cnt_x = XW'(count);
      if (cnt_x == '0) begin
         n_w = CW'(1);
      end else if (cnt_x > XW'(DEPTH)) begin
         n_w = CW'(DEPTH);
      end else begin
         n_w = CW'(cnt_x);
      end
      last_idx = PW'(n_w - CW'(1));
   end

   assign key_w = WIDTH'(req_value);

   // Load pointer wraps at the entry count
   always_comb begin
      wp_eff = (CW'(wp_ff) >= n_w) ? '0 : wp_ff;
      wp_inc = CW'(wp_eff) + CW'(1);
      wp_in  = (wp_inc >= n_w) ? '0 : PW'(wp_inc);
   end

   // Probe point and comparisons
   assign mid_sum = (LW+1)'(low_ff) + (LW+1)'(high_ff);
   assign mid_s   = LW'(mid_sum >>> 1);
   assign mid     = mid_s[PW-1:0];
   assign swap    = cur_ff > rd_data_ff;
   assign key_eq  = key_ff == rd_data_ff;
   assign key_lt  = key_ff < rd_data_ff;

   // Memory port selection per operation
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      rd_en   = 1'b0;
      rd_addr = '0;
      case (cmd.op)
         ssbs_pkg::OP_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
         end
         ssbs_pkg::OP_LOAD: begin
            wr_en   = 1'b1;
            wr_addr = wp_eff;
            wr_data = key_w;
         end
         ssbs_pkg::OP_START: begin
            rd_en = 1'b1;
         end
         ssbs_pkg::OP_FETCH_J: begin
            rd_en   = 1'b1;
            rd_addr = i_ff + PW'(1);
         end
         ssbs_pkg::OP_COMPARE: begin
            rd_en   = 1'b1;
            rd_addr = j_ff + PW'(1);
            wr_en   = swap;
            wr_addr = j_ff;
            wr_data = cur_ff;
         end
         ssbs_pkg::OP_WRITE_I: begin
            wr_en   = 1'b1;
            wr_addr = i_ff;
            wr_data = cur_ff;
            rd_en   = 1'b1;
            rd_addr = i_ff + PW'(1);
         end
         ssbs_pkg::OP_PROBE: begin
            rd_en   = 1'b1;
            rd_addr = mid;
         end
         ssbs_pkg::OP_FETCH_LOW: begin
            rd_en = 1'b1;
         end
         ssbs_pkg::OP_FETCH_HIGH: begin
            rd_en   = 1'b1;
            rd_addr = last_idx;
         end
         default: begin
         end
      endcase
   end

   // Store memory with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Next values of the working registers
   always_comb begin
      clr_in    = clr_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      key_in    = key_ff;
      cur_in    = cur_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      found_in  = found_ff;
      hit_in    = hit_ff;
      lowest_in = lowest_ff;
      case (cmd.op)
         ssbs_pkg::OP_CLEAR: begin
            clr_in = clr_ff + PW'(1);
         end
         ssbs_pkg::OP_START: begin
            key_in   = key_w;
            i_in     = '0;
            low_in   = '0;
            high_in  = $signed({1'b0, n_w}) - LW'(1);
            found_in = 1'b0;
            hit_in   = '0;
         end
         ssbs_pkg::OP_FETCH_J: begin
            cur_in = rd_data_ff;
            j_in   = i_ff + PW'(1);
         end
         ssbs_pkg::OP_COMPARE: begin
            if (swap) begin
               cur_in = rd_data_ff;
            end
            j_in = j_ff + PW'(1);
         end
         ssbs_pkg::OP_WRITE_I: begin
            i_in = i_ff + PW'(1);
         end
         ssbs_pkg::OP_DECIDE: begin
            if (key_eq) begin
               found_in = 1'b1;
               hit_in   = mid;
            end else if (key_lt) begin
               high_in = mid_s - LW'(1);
            end else begin
               low_in = mid_s + LW'(1);
            end
         end
         ssbs_pkg::OP_FETCH_HIGH: begin
            lowest_in = rd_data_ff;
         end
         default: begin
         end
      endcase
   end

   // Hold a result word until it is taken
   assign rsp_valid_in = cmd.rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.op == ssbs_pkg::OP_LOAD) begin
            wp_ff <= wp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      j_ff      <= j_in;
      key_ff    <= key_in;
      cur_ff    <= cur_in;
      low_ff    <= low_in;
      high_ff   <= high_in;
      found_ff  <= found_in;
      hit_ff    <= hit_in;
      lowest_ff <= lowest_in;
      if (cmd.rsp_load) begin
         rsp_found_ff    <= found_ff;
         rsp_position_ff <= PSW'(hit_ff);
         rsp_lowest_ff   <= to_word(lowest_ff);
         rsp_highest_ff  <= to_word(rd_data_ff);
      end
   end

   // Status to the controller
   always_comb begin
      status.clr_last    = clr_ff == PW'(DEPTH - 1);
      status.single      = n_w == CW'(1);
      status.j_last      = j_ff == last_idx;
      status.i_last      = (i_ff + PW'(1)) == last_idx;
      status.range_empty = low_ff > high_ff;
      status.hit         = key_eq;
      status.rsp_full    = rsp_valid_ff;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_lowest   = rsp_lowest_ff;
   assign rsp_highest  = rsp_highest_ff;

endmodule

FILE: rtl/core/ssbs_ctrl.sv
// Controller of the sorted store: clearing pass, load, exchange sort,
// binary search and reply sequencing.
// Depends on ssbs_pkg for state, operation and struct types.
module ssbs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_func,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   input  ssbs_pkg::status_type status,
   output ssbs_pkg::cmd_type    cmd
);

   ssbs_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssbs_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath command
   always_comb begin
      state_in     = state_ff;
      cmd.op       = ssbs_pkg::OP_NONE;
      cmd.rsp_load = 1'b0;
      req_ready    = 1'b0;
      unique case (state_ff)
         ssbs_pkg::ST_CLEAR: begin
            cmd.op = ssbs_pkg::OP_CLEAR;
            if (status.clr_last) begin
               state_in = ssbs_pkg::ST_IDLE;
            end
         end
         ssbs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_func == ssbs_pkg::FUNC_SEARCH) begin
                  cmd.op   = ssbs_pkg::OP_START;
                  state_in = status.single ? ssbs_pkg::ST_PROBE : ssbs_pkg::ST_FETCH_J;
               end else begin
                  cmd.op = ssbs_pkg::OP_LOAD;
               end
            end
         end
         ssbs_pkg::ST_FETCH_J: begin
            cmd.op   = ssbs_pkg::OP_FETCH_J;
            state_in = ssbs_pkg::ST_COMPARE;
         end
         ssbs_pkg::ST_COMPARE: begin
            cmd.op = ssbs_pkg::OP_COMPARE;
            if (status.j_last) begin
               state_in = ssbs_pkg::ST_WRITE_I;
            end
         end
         ssbs_pkg::ST_WRITE_I: begin
            cmd.op   = ssbs_pkg::OP_WRITE_I;
            state_in = status.i_last ? ssbs_pkg::ST_PROBE : ssbs_pkg::ST_FETCH_J;
         end
         ssbs_pkg::ST_PROBE: begin
            cmd.op   = ssbs_pkg::OP_PROBE;
            state_in = status.range_empty ? ssbs_pkg::ST_RD_LOW : ssbs_pkg::ST_DECIDE;
         end
         ssbs_pkg::ST_DECIDE: begin
            cmd.op   = ssbs_pkg::OP_DECIDE;
            state_in = status.hit ? ssbs_pkg::ST_RD_LOW : ssbs_pkg::ST_PROBE;
         end
         ssbs_pkg::ST_RD_LOW: begin
            cmd.op   = ssbs_pkg::OP_FETCH_LOW;
            state_in = ssbs_pkg::ST_RD_HIGH;
         end
         ssbs_pkg::ST_RD_HIGH: begin
            cmd.op   = ssbs_pkg::OP_FETCH_HIGH;
            state_in = ssbs_pkg::ST_REPLY;
         end
         ssbs_pkg::ST_REPLY: begin
            if (!status.rsp_full || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ssbs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ssbs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/core/sorted_store_binary_search_top.sv
// Load word: accepted while idle, next word may follow at once.
// Search word: the store is sorted with one compare per cycle on the single-read-port
// store, then binary-searched, and the reply follows. One word at a time.
// Reset: clears the store with req_ready low; CSR stays open.
module sorted_store_binary_search_top #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_func,
   input  logic signed [ssbs_pkg::VALUE_W-1:0]     req_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_found,
   output logic [ssbs_pkg::POS_W-1:0]              rsp_position,
   output logic signed [ssbs_pkg::VALUE_W-1:0]     rsp_lowest,
   output logic signed [ssbs_pkg::VALUE_W-1:0]     rsp_highest,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [ssbs_pkg::CSR_AW-1:0]             csr_paddr,
   input  logic [ssbs_pkg::CSR_DW-1:0]             csr_pwdata,
   output logic [ssbs_pkg::CSR_DW-1:0]             csr_prdata,
   output logic                                    csr_pready
);

   localparam int DW = ssbs_pkg::CSR_DW;

   logic [ssbs_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                         csr_wr;
   ssbs_pkg::cmd_type            cmd;
   ssbs_pkg::status_type         status;

   // Register write on the access phase
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == ssbs_pkg::REG_ELEMENT_COUNT);
   assign count_in   = csr_wr ? csr_pwdata[ssbs_pkg::COUNT_W-1:0] : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= ssbs_pkg::COUNT_RESET;
      end else begin
         count_ff <= count_in;
      end
   end

   // Read back the entry count at its own address
   assign csr_prdata = (csr_paddr == '0) ? DW'(count_ff) : '0;

   ssbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ssbs_dp #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_value    (req_value),
      .count        (count_ff),
      .rsp_ready    (rsp_ready),
      .rsp_valid    (rsp_valid),
      .rsp_found    (rsp_found),
      .rsp_position (rsp_position),
      .rsp_lowest   (rsp_lowest),
      .rsp_highest  (rsp_highest)
   );

endmodule

FILE: rtl/core/ssbs_checker.sv
// Port checker for the sorted store with binary search, bound to the top.
// Depends on ssbs_pkg for the function codes and field widths.
module ssbs_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                req_func,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_found,
   input logic [ssbs_pkg::POS_W-1:0]          rsp_position,
   input logic signed [ssbs_pkg::VALUE_W-1:0] rsp_lowest,
   input logic signed [ssbs_pkg::VALUE_W-1:0] rsp_highest
);

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) &&
      $stable(rsp_position) && $stable(rsp_lowest) && $stable(rsp_highest))
      else $error("result word changed while stalled");

   // A miss reports position zero
   a_miss_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_position == '0)
      else $error("miss with nonzero position");

   // Sorted store puts the smallest entry first
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_lowest <= rsp_highest)
      else $error("lowest above highest");

   // A search keeps the block busy
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func == ssbs_pkg::FUNC_SEARCH |=> !req_ready)
      else $error("ready straight after a search word");

endmodule

bind sorted_store_binary_search_top ssbs_checker u_ssbs_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .req_func     (req_func),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_found    (rsp_found),
   .rsp_position (rsp_position),
   .rsp_lowest   (rsp_lowest),
   .rsp_highest  (rsp_highest)
);
